// ----- hdl/four_level_page_table_walker_macros.svh -----
// assertion macros for the page table walker checker
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_MACROS_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_MACROS_SVH

// property checked at every edge out of reset
`define FPTW_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication into the next cycle
`define FPTW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/fptw_pkg.sv -----
`timescale 1ns / 1ps
package fptw_pkg;

  localparam int unsigned VaW     = 48;
  localparam int unsigned PaW     = 52;
  localparam int unsigned EntryW  = 64;
  localparam int unsigned QDepth  = 2;
  localparam int unsigned QPtrW   = $clog2(QDepth);
  localparam int unsigned QCntW   = $clog2(QDepth + 1);

  localparam logic OpTranslate = 1'b0;
  localparam logic OpResponse  = 1'b1;

  localparam logic KindRead = 1'b0;
  localparam logic KindDone = 1'b1;

  localparam logic [1:0] StOk         = 2'd0;
  localparam logic [1:0] StNotPresent = 2'd1;
  localparam logic [1:0] StReadFail   = 2'd2;
  localparam logic [1:0] StBusy       = 2'd3;

  localparam logic [1:0] LvlPml4 = 2'd0;
  localparam logic [1:0] LvlPdpt = 2'd1;
  localparam logic [1:0] LvlPd   = 2'd2;
  localparam logic [1:0] LvlPt   = 2'd3;

  localparam int unsigned PresentBit = 0;
  localparam int unsigned LargeBit   = 7;

  typedef struct packed {
    logic              is_resp;
    logic [VaW-1:0]    virt_addr;
    logic [PaW-1:0]    first_addr;
    logic [EntryW-1:0] read_data;
    logic              read_ok;
  } item_t;

  typedef struct packed {
    logic           kind;
    logic [PaW-1:0] read_addr;
    logic [PaW-1:0] phys_addr;
    logic [1:0]     status;
  } res_t;

  // 9-bit table index of a virtual address at a level
  function automatic logic [8:0] table_index(logic [VaW-1:0] va, logic [1:0] lvl);
    logic [8:0] idx;
    case (lvl)
      LvlPml4: idx = va[47:39];
      LvlPdpt: idx = va[38:30];
      LvlPd:   idx = va[29:21];
      LvlPt:   idx = va[20:12];
      default: idx = va[47:39];
    endcase
    return idx;
  endfunction

endpackage

// ----- hdl/fptw_front.sv -----
`timescale 1ns / 1ps
module fptw_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic                         opcode_i,
  input  logic [fptw_pkg::VaW-1:0]     virt_addr_i,
  input  logic [63:0]                  table_base_i,
  input  logic [fptw_pkg::EntryW-1:0]  read_data_i,
  input  logic                         read_ok_i,
  output logic                         item_valid_o,
  input  logic                         item_ready_i,
  output fptw_pkg::item_t              item_o
);
  import fptw_pkg::*;

  item_t            mem_q [QDepth];
  item_t            item_in;
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  // classify and precompute the top-level entry address
  always_comb begin
    item_in.is_resp    = (opcode_i == OpResponse);
    item_in.virt_addr  = virt_addr_i;
    item_in.first_addr = {table_base_i[51:12], table_index(virt_addr_i, LvlPml4), 3'b000};
    item_in.read_data  = read_data_i;
    item_in.read_ok    = read_ok_i;
  end

  assign full         = (cnt_q == QCntW'(QDepth));
  assign do_push      = push && !full;
  assign item_valid_o = (cnt_q != '0);
  assign do_pop       = item_valid_o && item_ready_i;
  assign item_o       = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

// ----- hdl/fptw_back.sv -----
`timescale 1ns / 1ps
module fptw_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     item_valid_i,
  output logic                     item_ready_o,
  input  fptw_pkg::item_t          item_i,
  output logic                     empty,
  input  logic                     pop,
  output logic                     kind_o,
  output logic [fptw_pkg::PaW-1:0] read_addr_o,
  output logic [fptw_pkg::PaW-1:0] phys_addr_o,
  output logic [1:0]               status_o
);
  import fptw_pkg::*;

  logic             active_q, active_d;
  logic [1:0]       level_q, level_d;
  logic [VaW-1:0]   va_q, va_d;
  res_t             res;
  logic             res_valid;
  logic             take;
  logic [EntryW-1:0] e;

  res_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign item_ready_o = (cnt_q != QCntW'(QDepth));
  assign take         = item_valid_i && item_ready_o;
  assign e            = item_i.read_data;

  // walk step
  always_comb begin
    active_d  = active_q;
    level_d   = level_q;
    va_d      = va_q;
    res_valid = 1'b0;
    res       = '0;
    if (take) begin
      if (!item_i.is_resp) begin
        res_valid = 1'b1;
        if (active_q) begin
          res.kind   = KindDone;
          res.status = StBusy;
        end else begin
          active_d      = 1'b1;
          level_d       = LvlPml4;
          va_d          = item_i.virt_addr;
          res.kind      = KindRead;
          res.read_addr = item_i.first_addr;
        end
      end else if (active_q) begin
        res_valid = 1'b1;
        res.kind  = KindDone;
        if (!item_i.read_ok) begin
          active_d   = 1'b0;
          res.status = StReadFail;
        end else if (!e[PresentBit]) begin
          active_d   = 1'b0;
          res.status = StNotPresent;
        end else if (level_q == LvlPdpt && e[LargeBit]) begin
          active_d      = 1'b0;
          res.phys_addr = {e[51:30], va_q[29:0]};
        end else if (level_q == LvlPd && e[LargeBit]) begin
          active_d      = 1'b0;
          res.phys_addr = {e[51:21], va_q[20:0]};
        end else if (level_q == LvlPt) begin
          active_d      = 1'b0;
          res.phys_addr = {e[51:12], va_q[11:0]};
        end else begin
          level_d       = level_q + 2'd1;
          res.kind      = KindRead;
          res.read_addr = {e[51:12], table_index(va_q, level_q + 2'd1), 3'b000};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      level_q  <= LvlPml4;
      va_q     <= '0;
    end else begin
      active_q <= active_d;
      level_q  <= level_d;
      va_q     <= va_d;
    end
  end

  // result queue
  assign do_push = res_valid;
  assign empty   = (cnt_q == '0);
  assign do_pop  = pop && !empty;

  assign kind_o      = mem_q[rd_ptr_q].kind;
  assign read_addr_o = mem_q[rd_ptr_q].read_addr;
  assign phys_addr_o = mem_q[rd_ptr_q].phys_addr;
  assign status_o    = mem_q[rd_ptr_q].status;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= res;
    end
  end

endmodule

// ----- hdl/four_level_page_table_walker.sv -----
`timescale 1ns / 1ps
// channel   handshake        payload
// input     push / full      opcode_i virt_addr_i table_base_i read_data_i read_ok_i
// result    empty / pop      kind_o read_addr_o phys_addr_o status_o
//
// one item per cycle sustained unless pop stalls; a result reaches the result ports
// once its beat is held in the input queue, then its result in the result queue
// reset clears both queues and leaves the walker idle
// a stalled result side fills the result queue, then the input queue, then full rises
// a response beat taken while idle yields no result
module four_level_page_table_walker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push,
  output logic                     full,
  input  logic                     opcode_i,
  input  logic [fptw_pkg::VaW-1:0] virt_addr_i,
  input  logic [63:0]              table_base_i,
  input  logic [fptw_pkg::EntryW-1:0] read_data_i,
  input  logic                     read_ok_i,
  output logic                     empty,
  input  logic                     pop,
  output logic                     kind_o,
  output logic [fptw_pkg::PaW-1:0] read_addr_o,
  output logic [fptw_pkg::PaW-1:0] phys_addr_o,
  output logic [1:0]               status_o
);
  import fptw_pkg::*;

  item_t item;
  logic  item_valid, item_ready;

  fptw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .opcode_i     (opcode_i),
    .virt_addr_i  (virt_addr_i),
    .table_base_i (table_base_i),
    .read_data_i  (read_data_i),
    .read_ok_i    (read_ok_i),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  fptw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .empty        (empty),
    .pop          (pop),
    .kind_o       (kind_o),
    .read_addr_o  (read_addr_o),
    .phys_addr_o  (phys_addr_o),
    .status_o     (status_o)
  );

endmodule

// ----- hdl/fptw_checker.sv -----
`timescale 1ns / 1ps
`include "four_level_page_table_walker_macros.svh"
module fptw_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     empty,
  input logic                     pop,
  input logic                     kind_o,
  input logic [fptw_pkg::PaW-1:0] read_addr_o,
  input logic [fptw_pkg::PaW-1:0] phys_addr_o,
  input logic [1:0]               status_o
);
  import fptw_pkg::*;

  `FPTW_ASSERT_NEXT(a_res_held, clk_i, rst_ni, !empty && !pop, !empty, "result withdrawn")
  `FPTW_ASSERT_NEXT(a_res_stable, clk_i, rst_ni, !empty && !pop, $stable({kind_o, read_addr_o, phys_addr_o, status_o}), "stalled result changed")
  `FPTW_ASSERT(a_read_clean, clk_i, rst_ni, empty || kind_o != KindRead || (status_o == StOk && phys_addr_o == '0), "read request carries result fields")
  `FPTW_ASSERT(a_done_clean, clk_i, rst_ni, empty || kind_o != KindDone || (read_addr_o == '0 && (status_o == StOk || phys_addr_o == '0)), "finished result carries stray address")

endmodule

bind four_level_page_table_walker fptw_checker u_fptw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .empty       (empty),
  .pop         (pop),
  .kind_o      (kind_o),
  .read_addr_o (read_addr_o),
  .phys_addr_o (phys_addr_o),
  .status_o    (status_o)
);

// ----- tb/four_level_page_table_walker_test.sv -----
`timescale 1ns / 1ps
module four_level_page_table_walker_test;
  import fptw_pkg::*;

  typedef struct packed {
    logic              op;
    logic [VaW-1:0]    va;
    logic [63:0]       tb;
    logic [EntryW-1:0] rd;
    logic              rok;
    logic              pinned;
    logic              answers;
    res_t              res;
  } beat_t;

  localparam int unsigned NumRows    = 25;
  localparam int unsigned WalkTarget = 550;
  localparam int unsigned StallLimit = 1000;

  localparam logic [63:0] FrameMask = 64'h000F_FFFF_FFFF_F000;
  localparam logic [63:0] GigMask   = 64'h000F_FFFF_C000_0000;
  localparam logic [63:0] Mib2Mask  = 64'h000F_FFFF_FFE0_0000;
  localparam logic [63:0] AllOnes   = '1;
  localparam logic [47:0] VaOnes    = '1;

  localparam res_t NoRes     = '0;
  localparam res_t ZeroRead  = '{kind: KindRead, read_addr: '0, phys_addr: '0, status: StOk};
  localparam res_t BusyRes   = '{kind: KindDone, read_addr: '0, phys_addr: '0, status: StBusy};
  localparam res_t FailRes   = '{kind: KindDone, read_addr: '0, phys_addr: '0,
                                 status: StReadFail};
  localparam res_t AbsentRes = '{kind: KindDone, read_addr: '0, phys_addr: '0,
                                 status: StNotPresent};

  // op, va, table base, entry, read ok, pinned, answers, pinned result
  localparam beat_t StimTable [NumRows] = '{
    '{OpResponse,  48'h0,            64'h0,   64'h81,  1'b1, 1'b1, 1'b0, NoRes},
    '{OpTranslate, 48'h0,            64'h0,   64'h0,   1'b1, 1'b1, 1'b1, ZeroRead},
    '{OpTranslate, VaOnes,           AllOnes, AllOnes, 1'b1, 1'b1, 1'b1, BusyRes},
    '{OpResponse,  48'h0,            64'h0,   AllOnes, 1'b0, 1'b1, 1'b1, FailRes},
    '{OpResponse,  VaOnes,           AllOnes, 64'h0,   1'b0, 1'b1, 1'b0, NoRes},
    '{OpTranslate, VaOnes,           AllOnes, 64'h0,   1'b0, 1'b0, 1'b0, NoRes},
    '{OpResponse,  48'h0,            64'h0,   AllOnes, 1'b1, 1'b0, 1'b0, NoRes},
    '{OpResponse,  48'h0,            64'h0,   AllOnes, 1'b1, 1'b0, 1'b0, NoRes},
    '{OpTranslate, 48'h1234_5678_9ABC, 64'hFFF0_0000_0000_0FFF, 64'h0, 1'b1, 1'b0, 1'b0,
      NoRes},
    '{OpResponse,  48'h0, 64'h0, 64'h8000_0000_0000_0001, 1'b1, 1'b0, 1'b0, NoRes},
    '{OpResponse,  48'h0, 64'h0, 64'h000A_BCDE_F012_3001, 1'b1, 1'b0, 1'b0, NoRes},
    '{OpResponse,  48'h0, 64'h0, 64'h0005_5555_5540_0081, 1'b1, 1'b0, 1'b0, NoRes},
    '{OpTranslate, VaOnes,           64'h0,   64'h0,   1'b1, 1'b0, 1'b0, NoRes},
    '{OpResponse,  48'h0,            64'h0,   64'h1,   1'b1, 1'b0, 1'b0, NoRes},
    '{OpResponse,  48'h0,            64'h0,   64'h1,   1'b1, 1'b0, 1'b0, NoRes},
    '{OpResponse,  48'h0,            64'h0,   64'h1,   1'b1, 1'b0, 1'b0, NoRes},
    '{OpResponse,  48'h0,            64'h0,   AllOnes, 1'b1, 1'b0, 1'b0, NoRes},
    '{OpTranslate, 48'h0,            AllOnes, 64'h0,   1'b1, 1'b0, 1'b0, NoRes},
    '{OpResponse,  48'h0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 1'b1, 1'b1, AbsentRes},
    '{OpTranslate, 48'h0,            64'h0,   64'h0,   1'b1, 1'b1, 1'b1, ZeroRead},
    '{OpResponse,  48'h0,            64'h0,   64'h81,  1'b1, 1'b0, 1'b0, NoRes},
    '{OpResponse,  48'h0,            64'h0,   64'h1,   1'b1, 1'b0, 1'b0, NoRes},
    '{OpResponse,  48'h0,            64'h0,   64'h1,   1'b1, 1'b0, 1'b0, NoRes},
    '{OpResponse,  48'h0,            64'h0,   64'h0,   1'b1, 1'b1, 1'b1, AbsentRes},
    '{OpResponse,  48'h0,            64'h0,   64'h1,   1'b1, 1'b1, 1'b0, NoRes}
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic push;
  logic full;
  logic empty;
  logic pop;
  logic opcode_i;
  logic [VaW-1:0] virt_addr_i;
  logic [63:0] table_base_i;
  logic [EntryW-1:0] read_data_i;
  logic read_ok_i;
  logic kind_o;
  logic [PaW-1:0] read_addr_o;
  logic [PaW-1:0] phys_addr_o;
  logic [1:0] status_o;

  beat_t cur_beat = '0;
  res_t due_results [$];
  int errors = 0;
  int stall_cycles = 0;
  int answered = 0;
  bit calm_push = 1'b0;
  bit calm_pop = 1'b0;

  // walker state as the block should hold it
  logic walking = 1'b0;
  logic [1:0] depth = LvlPml4;
  logic [VaW-1:0] held_va = '0;

  assign opcode_i     = cur_beat.op;
  assign virt_addr_i  = cur_beat.va;
  assign table_base_i = cur_beat.tb;
  assign read_data_i  = cur_beat.rd;
  assign read_ok_i    = cur_beat.rok;

  always #5 clk_i = ~clk_i;

  four_level_page_table_walker dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .opcode_i     (opcode_i),
    .virt_addr_i  (virt_addr_i),
    .table_base_i (table_base_i),
    .read_data_i  (read_data_i),
    .read_ok_i    (read_ok_i),
    .empty        (empty),
    .pop          (pop),
    .kind_o       (kind_o),
    .read_addr_o  (read_addr_o),
    .phys_addr_o  (phys_addr_o),
    .status_o     (status_o)
  );

  function automatic bit walk_step(input beat_t b, output res_t r);
    logic [63:0] entry;
    logic [8:0] idx;
    r = '0;
    if (b.op == OpTranslate) begin
      if (walking) begin
        r.kind = KindDone;
        r.status = StBusy;
        return 1'b1;
      end
      walking = 1'b1;
      depth = LvlPml4;
      held_va = b.va;
      r.kind = KindRead;
      r.read_addr = PaW'((b.tb & FrameMask) + {b.va[47:39], 3'b000});
      return 1'b1;
    end
    if (!walking) return 1'b0;
    r.kind = KindDone;
    entry = b.rd;
    if (!b.rok) begin
      walking = 1'b0;
      r.status = StReadFail;
    end else if (!entry[PresentBit]) begin
      walking = 1'b0;
      r.status = StNotPresent;
    end else if (depth == LvlPdpt && entry[LargeBit]) begin
      walking = 1'b0;
      r.phys_addr = PaW'((entry & GigMask) + held_va[29:0]);
    end else if (depth == LvlPd && entry[LargeBit]) begin
      walking = 1'b0;
      r.phys_addr = PaW'((entry & Mib2Mask) + held_va[20:0]);
    end else if (depth == LvlPt) begin
      walking = 1'b0;
      r.phys_addr = PaW'((entry & FrameMask) + held_va[11:0]);
    end else begin
      depth = depth + 2'd1;
      idx = 9'(held_va >> (39 - 9 * depth));
      r.kind = KindRead;
      r.read_addr = PaW'((entry & FrameMask) + {idx, 3'b000});
    end
    return 1'b1;
  endfunction

  task automatic compare_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t %s mismatch: expected %h actual %h", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    res_t want;
    res_t pred;
    bit produced;
    bit moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (pop && !empty) begin
        moved = 1'b1;
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t unexpected result: expected none actual %h %h %h %h", $time,
                   kind_o, read_addr_o, phys_addr_o, status_o);
        end else begin
          want = due_results.pop_front();
          compare_field("kind", want.kind, kind_o);
          compare_field("read_addr", want.read_addr, read_addr_o);
          compare_field("phys_addr", want.phys_addr, phys_addr_o);
          compare_field("status", want.status, status_o);
        end
      end
      if (push && !full) begin
        moved = 1'b1;
        produced = walk_step(cur_beat, pred);
        if (cur_beat.pinned) begin
          if (cur_beat.answers) due_results.push_back(cur_beat.res);
        end else if (produced) begin
          due_results.push_back(pred);
        end
      end
      if (moved) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= StallLimit) begin
          $display("FAIL four_level_page_table_walker");
          $finish;
        end
      end
    end
  end

  task automatic send_beat(input beat_t b);
    int gap;
    if ($urandom_range(0, 39) == 0) calm_push = !calm_push;
    gap = calm_push ? 0 : $urandom_range(0, 16);
    @(negedge clk_i);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cur_beat <= b;
    push <= 1'b1;
    do @(posedge clk_i); while (full);
  endtask

  function automatic beat_t random_beat(input logic op);
    beat_t b;
    b = '0;
    b.op = op;
    b.va = VaW'({$urandom, $urandom});
    b.tb = {$urandom, $urandom};
    b.rd = {$urandom, $urandom};
    b.rok = 1'($urandom_range(0, 1));
    return b;
  endfunction

  task automatic maybe_busy();
    if ($urandom_range(0, 9) == 0) begin
      send_beat(random_beat(OpTranslate));
      answered++;
    end
  endtask

  // one walk with random content; the walk shape is drawn up front
  task automatic run_walk();
    beat_t b;
    int last_lvl;
    int ending;
    last_lvl = $urandom_range(0, 3);
    ending = $urandom_range(0, 9);
    if (last_lvl == 0) ending = ending % 2;
    send_beat(random_beat(OpTranslate));
    answered++;
    maybe_busy();
    for (int lvl = 0; lvl <= last_lvl; lvl++) begin
      b = random_beat(OpResponse);
      b.rok = 1'b1;
      b.rd[PresentBit] = 1'b1;
      if (lvl < last_lvl) begin
        if (lvl != 0) b.rd[LargeBit] = 1'b0;
      end else if (ending == 0) begin
        b.rok = 1'b0;
      end else if (ending == 1) begin
        b.rd[PresentBit] = 1'b0;
      end else if (lvl != 3) begin
        b.rd[LargeBit] = 1'b1;
      end
      send_beat(b);
      answered++;
      if (lvl < last_lvl) maybe_busy();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    push = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < NumRows; i++) send_beat(StimTable[i]);
    while (answered < WalkTarget) begin
      // stray response beat while idle
      if ($urandom_range(0, 11) == 0) send_beat(random_beat(OpResponse));
      run_walk();
    end
    @(negedge clk_i);
    push <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS four_level_page_table_walker");
    end else begin
      $display("FAIL four_level_page_table_walker");
    end
    $finish;
  end

  initial begin
    int gap;
    pop = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 39) == 0) calm_pop = !calm_pop;
      gap = calm_pop ? 0 : $urandom_range(0, 16);
      @(negedge clk_i);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
    end
  end

endmodule
